### src/brapq_pkg.sv
package brapq_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 11;
  localparam int AMT_W  = 16;
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // item kinds; code 3 is unused
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

endpackage

### src/block_range_add_point_query_unit.sv
// Range add: split, plan, then read-modify-write walks over the first partial block's points,
//   whole blocks' tags, last partial block's points; one-block add: points only; empty: no-op.
// Query: busy in S_DIV, S_QRD, S_QOUT, then a result strobe; out-of-span strobes 0 next cycle.
// Clear: a sweep over max(POSITIONS, NUM_BLOCKS) entries, one entry of each store per cycle.
// Reset (rst_n low, synchronous) starts the same clearing pass; busy stays high during it.
// Results cannot be stalled; each is on out_value for the single cycle out_valid is high.
module block_range_add_point_query_unit #(
  parameter int POSITIONS  = 1024,
  parameter int BLOCK_SIZE = 32,
  parameter int NUM_BLOCKS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [brapq_pkg::KIND_W-1:0]          in_kind,
  input  logic [brapq_pkg::POS_W-1:0]           in_position,
  input  logic [brapq_pkg::POS_W-1:0]           in_last_position,
  input  logic signed [brapq_pkg::AMT_W-1:0]    in_amount,
  // result strobe
  output logic                                  out_valid,
  output logic signed [brapq_pkg::VAL_W-1:0]    out_value,
  // config write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [brapq_pkg::CFG_W-1:0]           cfg_data
);

  localparam int PW  = brapq_pkg::POS_W;
  localparam int VW  = brapq_pkg::VAL_W;
  localparam int AMW = brapq_pkg::AMT_W;
  localparam int AW  = $clog2(POSITIONS);
  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int RW  = $clog2(BLOCK_SIZE);
  // walker / sweep counter covers both stores plus one past the end
  localparam int WW  = (AW > BW) ? AW + 1 : BW + 1;
  localparam int CLR_LAST = ((POSITIONS > NUM_BLOCKS) ? POSITIONS : NUM_BLOCKS) - 1;
  // index / BLOCK_SIZE as a multiply by the rounded-up reciprocal and a shift;
  // exact for every PW-bit index
  localparam int     DSH  = PW + RW;
  localparam int     MW   = PW + 2;
  localparam longint DMUL = ((longint'(1) << DSH) + longint'(BLOCK_SIZE) - 1)
                            / longint'(BLOCK_SIZE);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_PLAN, S_PTS1, S_TAGS, S_PTS2, S_QRD, S_QOUT
  } state_t;

  // block number of an index, before clamping
  function automatic logic [PW-1:0] blk_quot(input logic [PW-1:0] idx);
    logic [PW+MW-1:0] prod;
    prod = {{MW{1'b0}}, idx} * (PW+MW)'(DMUL);
    return PW'(prod >> DSH);
  endfunction

  // offset of an index inside its block
  function automatic logic [RW-1:0] blk_rem(input logic [PW-1:0] idx,
                                            input logic [PW-1:0] q);
    logic [PW-1:0] base;
    base = PW'(32'(q) * BLOCK_SIZE);
    return RW'(idx - base);
  endfunction

  // last block absorbs everything above it
  function automatic logic [BW-1:0] clamp_blk(input logic [PW-1:0] q);
    if (32'(q) > NUM_BLOCKS - 1) begin
      return BW'(NUM_BLOCKS - 1);
    end
    return BW'(q);
  endfunction

  state_t                     state_r, state_nxt;
  logic [brapq_pkg::CFG_W-1:0] cfg_r, cfg_nxt;
  brapq_pkg::kind_t           kind_r, kind_nxt;
  logic [PW-1:0]              fi_r, fi_nxt;       // first index (position - 1)
  logic [PW-1:0]              li_r, li_nxt;       // last index
  logic signed [AMW-1:0]      amt_r, amt_nxt;
  // block split: a = first index, b = last index
  logic [PW-1:0]              q_a_r, q_a_nxt, q_b_r, q_b_nxt;
  logic [RW-1:0]              rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  // range plan
  logic [BW-1:0]              bf_r, bf_nxt, bl_r, bl_nxt;
  logic                       same_r, same_nxt;
  logic [PW-1:0]              p2_from_r, p2_from_nxt;
  // read-modify-write walker
  logic [WW-1:0]              walk_cur_r, walk_cur_nxt, walk_end_r, walk_end_nxt;
  logic                       pend_r, pend_nxt;
  logic [WW-1:0]              pend_addr_r, pend_addr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [VW-1:0]       out_value_r, out_value_nxt;

  logic [PW-1:0] span_w, f_w, l_w, hi_w;
  logic [PW-1:0] quot_a, quot_b;
  logic          bl_clamped;
  logic          accept;
  logic [VW-1:0] amt_ext;

  // store ports
  logic          ptr_we, tag_we;
  logic [AW-1:0] ptr_waddr, ptr_raddr;
  logic [BW-1:0] tag_waddr, tag_raddr;
  logic [VW-1:0] ptr_wdata, tag_wdata, ptr_rdata, tag_rdata;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign amt_ext   = {{(VW-AMW){amt_r[AMW-1]}}, amt_r};

  // covered span = min(positions_in_use, POSITIONS)
  assign span_w = (32'(cfg_r) > POSITIONS) ? PW'(POSITIONS) : cfg_r;
  assign f_w    = (in_position == '0) ? PW'(1) : in_position;
  assign l_w    = (in_last_position > span_w) ? span_w : in_last_position;

  assign quot_a = blk_quot(fi_r);
  assign quot_b = blk_quot(li_r);

  // end of first partial block, and whether the last block index is clamped
  assign bl_clamped = (32'(q_b_r) > NUM_BLOCKS - 1);
  assign hi_w       = (fi_r - PW'(rem_a_r)) + PW'(BLOCK_SIZE - 1);

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_valid ? cfg_data : cfg_r;
    kind_nxt      = kind_r;
    fi_nxt        = fi_r;
    li_nxt        = li_r;
    amt_nxt       = amt_r;
    q_a_nxt       = q_a_r;
    q_b_nxt       = q_b_r;
    rem_a_nxt     = rem_a_r;
    rem_b_nxt     = rem_b_r;
    bf_nxt        = bf_r;
    bl_nxt        = bl_r;
    same_nxt      = same_r;
    p2_from_nxt   = p2_from_r;
    walk_cur_nxt  = walk_cur_r;
    walk_end_nxt  = walk_end_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;

    case (state_r)
      S_CLR: begin
        // zero one entry of each store per cycle
        if (walk_cur_r == WW'(CLR_LAST)) begin
          state_nxt = S_IDLE;
        end else begin
          walk_cur_nxt = walk_cur_r + WW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          kind_nxt = brapq_pkg::kind_t'(in_kind);
          amt_nxt  = in_amount;
          rem_a_nxt = '0;
          rem_b_nxt = '0;
          q_a_nxt   = '0;
          q_b_nxt   = '0;
          case (brapq_pkg::kind_t'(in_kind))
            brapq_pkg::KIND_CLEAR: begin
              walk_cur_nxt = '0;
              state_nxt    = S_CLR;
            end
            brapq_pkg::KIND_ADD: begin
              // empty or fully above span: nothing to do
              if (f_w <= l_w) begin
                fi_nxt    = f_w - PW'(1);
                li_nxt    = l_w - PW'(1);
                state_nxt = S_DIV;
              end
            end
            brapq_pkg::KIND_QUERY: begin
              if ((in_position == '0) || (in_position > span_w)) begin
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
              end else begin
                fi_nxt    = in_position - PW'(1);
                li_nxt    = in_position - PW'(1);
                state_nxt = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DIV: begin
        q_a_nxt   = quot_a;
        q_b_nxt   = quot_b;
        rem_a_nxt = blk_rem(fi_r, quot_a);
        rem_b_nxt = blk_rem(li_r, quot_b);
        state_nxt = (kind_r == brapq_pkg::KIND_QUERY) ? S_QRD : S_PLAN;
      end

      S_PLAN: begin
        bf_nxt       = clamp_blk(q_a_r);
        bl_nxt       = clamp_blk(q_b_r);
        same_nxt     = (clamp_blk(q_a_r) == clamp_blk(q_b_r));
        p2_from_nxt  = bl_clamped ? PW'((NUM_BLOCKS - 1) * BLOCK_SIZE)
                                  : (li_r - PW'(rem_b_r));
        walk_cur_nxt = WW'(fi_r);
        walk_end_nxt = (clamp_blk(q_a_r) == clamp_blk(q_b_r)) ? WW'(li_r) : WW'(hi_w);
        state_nxt    = S_PTS1;
      end

      S_PTS1, S_TAGS, S_PTS2: begin
        // read entry cur now, write it back next cycle
        if (walk_cur_r <= walk_end_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = walk_cur_r;
          walk_cur_nxt  = walk_cur_r + WW'(1);
        end else begin
          // last pending write lands this cycle
          case (state_r)
            S_PTS1: begin
              if (same_r) begin
                state_nxt = S_IDLE;
              end else begin
                walk_cur_nxt = WW'(bf_r) + WW'(1);
                walk_end_nxt = WW'(bl_r) - WW'(1);
                state_nxt    = S_TAGS;
              end
            end
            S_TAGS: begin
              walk_cur_nxt = WW'(p2_from_r);
              walk_end_nxt = WW'(li_r);
              state_nxt    = S_PTS2;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_QRD: begin
        state_nxt = S_QOUT;
      end

      S_QOUT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = signed'(ptr_rdata + tag_rdata);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // store port muxing: sweep, walker write-back, query read
  always_comb begin
    ptr_raddr = (state_r == S_QRD) ? AW'(fi_r) : walk_cur_r[AW-1:0];
    tag_raddr = (state_r == S_QRD) ? clamp_blk(q_a_r) : walk_cur_r[BW-1:0];
    if (state_r == S_CLR) begin
      ptr_we    = (walk_cur_r < WW'(POSITIONS));
      ptr_waddr = walk_cur_r[AW-1:0];
      ptr_wdata = '0;
      tag_we    = (walk_cur_r < WW'(NUM_BLOCKS));
      tag_waddr = walk_cur_r[BW-1:0];
      tag_wdata = '0;
    end else begin
      ptr_we    = pend_r && ((state_r == S_PTS1) || (state_r == S_PTS2));
      ptr_waddr = pend_addr_r[AW-1:0];
      ptr_wdata = ptr_rdata + amt_ext;
      tag_we    = pend_r && (state_r == S_TAGS);
      tag_waddr = pend_addr_r[BW-1:0];
      tag_wdata = tag_rdata + amt_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cfg_r       <= brapq_pkg::CFG_RESET;
      walk_cur_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      walk_cur_r  <= walk_cur_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      fi_r        <= fi_nxt;
      li_r        <= li_nxt;
      amt_r       <= amt_nxt;
      q_a_r       <= q_a_nxt;
      q_b_r       <= q_b_nxt;
      rem_a_r     <= rem_a_nxt;
      rem_b_r     <= rem_b_nxt;
      bf_r        <= bf_nxt;
      bl_r        <= bl_nxt;
      same_r      <= same_nxt;
      p2_from_r   <= p2_from_nxt;
      walk_end_r  <= walk_end_nxt;
      pend_addr_r <= pend_addr_nxt;
      out_value_r <= out_value_nxt;
    end
  end

  // per-position offsets
  brapq_ram #(
    .WIDTH (VW),
    .DEPTH (POSITIONS)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  // per-block tags
  brapq_ram #(
    .WIDTH (VW),
    .DEPTH (NUM_BLOCKS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

`ifndef SYNTHESIS
  // walker never reads the entry it is writing back
  a_ptr_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_we && ((state_r == S_PTS1) || (state_r == S_PTS2))) |-> (ptr_waddr != ptr_raddr))
    else $error("point store read/write overlap");

  a_tag_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_we && (state_r == S_TAGS)) |-> (tag_waddr != tag_raddr))
    else $error("tag store read/write overlap");

  // a result follows only a finished lookup or an out-of-span query
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r == S_QOUT) ||
                     $past(start && !busy && (in_kind == brapq_pkg::KIND_QUERY))))
    else $error("result without query");
`endif

endmodule

### src/brapq_ram.sv
module brapq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
